/* rtl/pia_pkg.sv */
// ----------------------------------------------------------------------------
// pia_pkg
// Shared types and constants for the dual parallel port adapter.
// ----------------------------------------------------------------------------
package pia_pkg;

    // bus command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PINS  = 2'd2;

    // register offsets
    localparam logic [1:0] OFF_PORT_A = 2'd0;
    localparam logic [1:0] OFF_CTRL_A = 2'd1;
    localparam logic [1:0] OFF_PORT_B = 2'd2;
    localparam logic [1:0] OFF_CTRL_B = 2'd3;

    localparam logic [7:0] FLAG1_BIT = 8'h80;
    localparam logic [7:0] FLAG2_BIT = 8'h40;
    localparam logic [7:0] CTRL_MASK = 8'h3F;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // control register bit positions
    localparam int C_C1_IRQ_EN = 0;
    localparam int C_C1_EDGE   = 1;
    localparam int C_PORT_SEL  = 2;
    localparam int C_C2_B3     = 3;
    localparam int C_C2_B4     = 4;
    localparam int C_C2_OUT    = 5;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
        logic       ca1_level;
        logic       ca2_level_in;
        logic       cb1_level;
        logic       cb2_level_in;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_a_line;
        logic       irq_b_line;
        logic [7:0] port_a_drive;
        logic [7:0] port_b_drive;
        logic       ca2_level_out;
        logic       cb2_level_out;
        logic       ca2_strobe;
        logic       cb2_strobe;
    } result_t;

    // flags: b0 A1, b1 A2, b2 B1, b3 B2; c2_lvl: b0 CA2, b1 CB2;
    // line_lat: b0 CA1, b1 CA2, b2 CB1, b3 CB2
    typedef struct packed {
        logic [7:0] out_a;
        logic [7:0] out_b;
        logic [7:0] dir_a;
        logic [7:0] dir_b;
        logic [5:0] ctrl_a;
        logic [5:0] ctrl_b;
        logic [3:0] flags;
        logic [1:0] c2_lvl;
        logic [7:0] pins_a;
        logic [7:0] pins_b;
        logic [3:0] line_lat;
    } state_t;

    localparam state_t STATE_RESET = '{
        out_a:    8'h00,
        out_b:    8'h00,
        dir_a:    8'h00,
        dir_b:    8'h00,
        ctrl_a:   6'h00,
        ctrl_b:   6'h00,
        flags:    4'h0,
        c2_lvl:   2'b00,
        pins_a:   BYTE_MASK,
        pins_b:   8'h00,
        line_lat: 4'h0
    };

endpackage

/* rtl/pia_if.sv */
// ----------------------------------------------------------------------------
// pia_if
// Handshake channels for the adapter: command words in, result words out.
// ----------------------------------------------------------------------------
interface pia_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [1:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
    logic       ca1_level;
    logic       ca2_level_in;
    logic       cb1_level;
    logic       cb2_level_in;

    modport source (
        output valid, command, reg_offset, write_data, port_a_pins, port_b_pins,
               ca1_level, ca2_level_in, cb1_level, cb2_level_in,
        input  ready
    );
    modport sink (
        input  valid, command, reg_offset, write_data, port_a_pins, port_b_pins,
               ca1_level, ca2_level_in, cb1_level, cb2_level_in,
        output ready
    );
endinterface

interface pia_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_a_line;
    logic       irq_b_line;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
    logic       ca2_level_out;
    logic       cb2_level_out;
    logic       ca2_strobe;
    logic       cb2_strobe;

    modport source (
        output valid, read_data, irq_a_line, irq_b_line, port_a_drive, port_b_drive,
               ca2_level_out, cb2_level_out, ca2_strobe, cb2_strobe,
        input  ready
    );
    modport sink (
        input  valid, read_data, irq_a_line, irq_b_line, port_a_drive, port_b_drive,
               ca2_level_out, cb2_level_out, ca2_strobe, cb2_strobe,
        output ready
    );
endinterface

/* rtl/pia_core.sv */
// ----------------------------------------------------------------------------
// pia_core
// Next-state and result logic for one word: register access, pin sampling,
// edge detection, interrupt flags and CA2/CB2 handling.
// ----------------------------------------------------------------------------
module pia_core
    import pia_pkg::*;
(
    input  state_t  cur,
    input  item_t   item,
    output state_t  nxt,
    output result_t res
);

    always_comb
    begin
        state_t     n;
        logic [7:0] rd;
        logic       sa;
        logic       sb;
        logic       e_ca1;
        logic       e_ca2;
        logic       e_cb1;
        logic       e_cb2;

        n     = cur;
        rd    = 8'h00;
        sa    = 1'b0;
        sb    = 1'b0;
        e_ca1 = (cur.line_lat[0] != item.ca1_level)
                && (item.ca1_level == cur.ctrl_a[C_C1_EDGE]);
        e_ca2 = (cur.line_lat[1] != item.ca2_level_in)
                && (item.ca2_level_in == cur.ctrl_a[C_C2_B4]);
        e_cb1 = (cur.line_lat[2] != item.cb1_level)
                && (item.cb1_level == cur.ctrl_b[C_C1_EDGE]);
        e_cb2 = (cur.line_lat[3] != item.cb2_level_in)
                && (item.cb2_level_in == cur.ctrl_b[C_C2_B4]);

        case (item.command)
            CMD_READ:
            begin
                case (item.reg_offset)
                    OFF_PORT_A:
                    begin
                        if (cur.ctrl_a[C_PORT_SEL])
                        begin
                            rd = (~cur.dir_a & cur.pins_a) | (cur.dir_a & cur.out_a);
                            n.flags[1:0] = 2'b00;
                            // strobe mode: pulse low, restore now if b3 set
                            if (cur.ctrl_a[C_C2_OUT] && !cur.ctrl_a[C_C2_B4])
                            begin
                                if (cur.ctrl_a[C_C2_B3])
                                begin
                                    n.c2_lvl[0] = 1'b1;
                                    sa          = cur.c2_lvl[0];
                                end
                                else
                                begin
                                    n.c2_lvl[0] = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            rd = cur.dir_a;
                        end
                    end
                    OFF_CTRL_A:
                    begin
                        rd = {2'b00, cur.ctrl_a};
                        if (cur.flags[0])
                            rd = rd | FLAG1_BIT;
                        if (cur.flags[1] && !cur.ctrl_a[C_C2_OUT])
                            rd = rd | FLAG2_BIT;
                    end
                    OFF_PORT_B:
                    begin
                        if (cur.ctrl_b[C_PORT_SEL])
                        begin
                            rd = (cur.out_b & cur.dir_b) | (cur.pins_b & ~cur.dir_b);
                            // CB2 released by a port B read after a CB1 edge
                            if (cur.flags[2] && !cur.ctrl_b[C_C2_B4] && !cur.ctrl_b[C_C2_B3])
                                n.c2_lvl[1] = 1'b1;
                            n.flags[3:2] = 2'b00;
                        end
                        else
                        begin
                            rd = cur.dir_b;
                        end
                    end
                    default:
                    begin
                        rd = {2'b00, cur.ctrl_b};
                        if (cur.flags[2])
                            rd = rd | FLAG1_BIT;
                        if (cur.flags[3] && !cur.ctrl_b[C_C2_OUT])
                            rd = rd | FLAG2_BIT;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                case (item.reg_offset)
                    OFF_PORT_A:
                    begin
                        if (cur.ctrl_a[C_PORT_SEL])
                            n.out_a = item.write_data;
                        else
                            n.dir_a = item.write_data;
                    end
                    OFF_CTRL_A:
                    begin
                        n.ctrl_a = item.write_data[5:0] & CTRL_MASK[5:0];
                        if (item.write_data[C_C2_OUT])
                            n.c2_lvl[0] = item.write_data[C_C2_B4]
                                          ? item.write_data[C_C2_B3] : 1'b1;
                    end
                    OFF_PORT_B:
                    begin
                        if (cur.ctrl_b[C_PORT_SEL])
                        begin
                            n.out_b = item.write_data;
                            if (!cur.ctrl_b[C_C2_B4])
                            begin
                                if (cur.ctrl_b[C_C2_B3])
                                begin
                                    n.c2_lvl[1] = 1'b1;
                                    sb          = cur.c2_lvl[1];
                                end
                                else
                                begin
                                    n.c2_lvl[1] = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            n.dir_b = item.write_data;
                        end
                    end
                    default:
                    begin
                        n.ctrl_b    = item.write_data[5:0] & CTRL_MASK[5:0];
                        n.c2_lvl[1] = item.write_data[C_C2_B4]
                                      ? item.write_data[C_C2_B3] : 1'b1;
                    end
                endcase
            end
            CMD_PINS:
            begin
                n.pins_a   = item.port_a_pins;
                n.pins_b   = item.port_b_pins;
                n.line_lat = {item.cb2_level_in, item.cb1_level,
                              item.ca2_level_in, item.ca1_level};
                if (e_ca1)
                begin
                    n.flags[0] = 1'b1;
                    // CA2 released by the CA1 active edge
                    if (cur.ctrl_a[C_C2_OUT] && !cur.ctrl_a[C_C2_B4] && !cur.ctrl_a[C_C2_B3])
                        n.c2_lvl[0] = 1'b1;
                end
                if (e_ca2 && !cur.ctrl_a[C_C2_OUT])
                    n.flags[1] = 1'b1;
                if (e_cb1)
                    n.flags[2] = 1'b1;
                if (e_cb2 && !cur.ctrl_b[C_C2_OUT])
                    n.flags[3] = 1'b1;
            end
            default:
            begin
                n = cur;
            end
        endcase

        nxt               = n;
        res.read_data     = rd;
        res.irq_a_line    = (n.flags[0] & n.ctrl_a[C_C1_IRQ_EN]) | (n.flags[1] & n.ctrl_a[C_C2_B3]);
        res.irq_b_line    = (n.flags[2] & n.ctrl_b[C_C1_IRQ_EN]) | (n.flags[3] & n.ctrl_b[C_C2_B3]);
        res.port_a_drive  = (n.out_a & n.dir_a) | (n.pins_a & ~n.dir_a);
        res.port_b_drive  = n.out_b & n.dir_b;
        res.ca2_level_out = n.ctrl_a[C_C2_OUT] ? n.c2_lvl[0] : 1'b1;
        res.cb2_level_out = n.c2_lvl[1];
        res.ca2_strobe    = sa;
        res.cb2_strobe    = sb;
    end

endmodule

/* rtl/parallel_interface_adapter.sv */
// An accepted command word is held in the command register, its result word in
// the result register. One word per cycle unless rsp.ready stalls; the state
// updates in one pass of pia_core between the two registers.
// Reset (rst_n low, async): state registers and flags clear, the port A pin
// latch goes to all ones, both stages empty.
// ----------------------------------------------------------------------------
// parallel_interface_adapter
// Dual 8-bit parallel port adapter with per-side output, direction and
// control registers, control line edge detection and interrupt flags.
// ----------------------------------------------------------------------------
module parallel_interface_adapter
    import pia_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pia_in_if.sink      req,
    pia_out_if.source   rsp
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    item_t   req_item;
    logic    advance;

    assign req_item = '{
        command:      req.command,
        reg_offset:   req.reg_offset,
        write_data:   req.write_data,
        port_a_pins:  req.port_a_pins,
        port_b_pins:  req.port_b_pins,
        ca1_level:    req.ca1_level,
        ca2_level_in: req.ca2_level_in,
        cb1_level:    req.cb1_level,
        cb2_level_in: req.cb2_level_in
    };

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    pia_core u_core (
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (req.valid && req.ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            in_item_reg <= req_item;
        if (advance)
            out_res_reg <= res_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_res_reg.read_data;
    assign rsp.irq_a_line    = out_res_reg.irq_a_line;
    assign rsp.irq_b_line    = out_res_reg.irq_b_line;
    assign rsp.port_a_drive  = out_res_reg.port_a_drive;
    assign rsp.port_b_drive  = out_res_reg.port_b_drive;
    assign rsp.ca2_level_out = out_res_reg.ca2_level_out;
    assign rsp.cb2_level_out = out_res_reg.cb2_level_out;
    assign rsp.ca2_strobe    = out_res_reg.ca2_strobe;
    assign rsp.cb2_strobe    = out_res_reg.cb2_strobe;

endmodule

/* rtl/pia_checker.sv */
// ----------------------------------------------------------------------------
// pia_checker
// Port-level checks on the adapter's command and result channels.
// ----------------------------------------------------------------------------
module pia_checker
    import pia_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input result_t    out_res
);

    // a stalled result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_res))
        else $error("result word changed while stalled");

    // with the result side empty, the command side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("command stalled with empty result stage");

    // with the result stage empty, an accepted word reaches the result side
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |-> ##2 out_valid)
        else $error("accepted word did not reach the result stage");

endmodule

bind parallel_interface_adapter pia_checker u_pia_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_res   ({rsp.read_data, rsp.irq_a_line, rsp.irq_b_line, rsp.port_a_drive,
                 rsp.port_b_drive, rsp.ca2_level_out, rsp.cb2_level_out,
                 rsp.ca2_strobe, rsp.cb2_strobe})
);

/* tb/tb_parallel_interface_adapter.sv */
// ----------------------------------------------------------------------------
// tb_parallel_interface_adapter
// Drives bus reads, bus writes and pin updates into the dual port adapter and
// checks every result word against a cycle-free predictor of the adapter
// registers, edge latches and interrupt flags. A short table of directed
// words comes first, then random register sequences with noise, under bursty
// command traffic and a receiver that stalls on its own schedule.
// ----------------------------------------------------------------------------
module tb_parallel_interface_adapter;
    import pia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE = 2'd3;   // unused command, changes nothing

    // flag, level and line latch bit positions
    localparam int FLG_A1 = 0;
    localparam int FLG_A2 = 1;
    localparam int FLG_B1 = 2;
    localparam int FLG_B2 = 3;
    localparam int LVL_CA2 = 0;
    localparam int LVL_CB2 = 1;
    localparam int LAT_CA1 = 0;
    localparam int LAT_CA2 = 1;
    localparam int LAT_CB1 = 2;
    localparam int LAT_CB2 = 3;

    localparam int RANDOM_WORDS  = 500;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 50;

    // outputs right after reset with nothing written
    localparam result_t RESULT_AFTER_RESET = '{
        read_data:     8'h00,
        irq_a_line:    1'b0,
        irq_b_line:    1'b0,
        port_a_drive:  BYTE_MASK,
        port_b_drive:  8'h00,
        ca2_level_out: 1'b1,
        cb2_level_out: 1'b0,
        ca2_strobe:    1'b0,
        cb2_strobe:    1'b0
    };

    typedef enum {RX_STREAM, RX_RANDOM, RX_PATTERN, RX_STARVED} rx_mode_t;

    typedef struct {
        item_t   word;
        bit      typed;
        result_t want;
    } table_row_t;

    logic clk;
    logic rst_n;

    pia_in_if  cmd_ch ();
    pia_out_if res_ch ();

    parallel_interface_adapter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd_ch),
        .rsp   (res_ch)
    );

    state_t     adapter_st = STATE_RESET;
    result_t    awaited_results[$];
    item_t      plan_words[$];
    table_row_t directed_rows[$];
    int         mismatch_count = 0;
    int         burst_left = 0;
    bit         offering = 1'b0;
    bit         hold_request = 1'b0;
    int         cycle_count = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic take_edge(input int idx, input logic lvl, input logic rising);
        logic old;
        old = adapter_st.line_lat[idx];
        adapter_st.line_lat[idx] = lvl;
        return (old != lvl) && (lvl == rising);
    endfunction

    function automatic result_t next_result(input item_t w);
        result_t r;
        logic [7:0] rd;
        logic strobe_a;
        logic strobe_b;
        logic was_high;
        logic hit;
        rd = 8'h00;
        strobe_a = 1'b0;
        strobe_b = 1'b0;
        case (w.command)
            CMD_READ:
            begin
                case (w.reg_offset)
                    OFF_PORT_A:
                    begin
                        if (adapter_st.ctrl_a[C_PORT_SEL])
                        begin
                            rd = (~adapter_st.dir_a & adapter_st.pins_a)
                               | (adapter_st.dir_a & adapter_st.out_a);
                            adapter_st.flags[FLG_A2:FLG_A1] = 2'b00;
                            if (adapter_st.ctrl_a[C_C2_OUT] && !adapter_st.ctrl_a[C_C2_B4])
                            begin
                                was_high = adapter_st.c2_lvl[LVL_CA2];
                                adapter_st.c2_lvl[LVL_CA2] = 1'b0;
                                if (adapter_st.ctrl_a[C_C2_B3])
                                begin
                                    adapter_st.c2_lvl[LVL_CA2] = 1'b1;
                                    strobe_a = was_high;
                                end
                            end
                        end
                        else
                        begin
                            rd = adapter_st.dir_a;
                        end
                    end
                    OFF_CTRL_A:
                    begin
                        rd = {2'b00, adapter_st.ctrl_a};
                        if (adapter_st.flags[FLG_A1])
                            rd = rd | FLAG1_BIT;
                        if (adapter_st.flags[FLG_A2] && !adapter_st.ctrl_a[C_C2_OUT])
                            rd = rd | FLAG2_BIT;
                    end
                    OFF_PORT_B:
                    begin
                        if (adapter_st.ctrl_b[C_PORT_SEL])
                        begin
                            rd = (adapter_st.out_b & adapter_st.dir_b)
                               | (adapter_st.pins_b & ~adapter_st.dir_b);
                            // CB2 released by a port B read after a CB1 edge
                            if (adapter_st.flags[FLG_B1] && !adapter_st.ctrl_b[C_C2_B4]
                                && !adapter_st.ctrl_b[C_C2_B3])
                                adapter_st.c2_lvl[LVL_CB2] = 1'b1;
                            adapter_st.flags[FLG_B2:FLG_B1] = 2'b00;
                        end
                        else
                        begin
                            rd = adapter_st.dir_b;
                        end
                    end
                    default:
                    begin
                        rd = {2'b00, adapter_st.ctrl_b};
                        if (adapter_st.flags[FLG_B1])
                            rd = rd | FLAG1_BIT;
                        if (adapter_st.flags[FLG_B2] && !adapter_st.ctrl_b[C_C2_OUT])
                            rd = rd | FLAG2_BIT;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                case (w.reg_offset)
                    OFF_PORT_A:
                    begin
                        if (adapter_st.ctrl_a[C_PORT_SEL])
                            adapter_st.out_a = w.write_data;
                        else
                            adapter_st.dir_a = w.write_data;
                    end
                    OFF_CTRL_A:
                    begin
                        adapter_st.ctrl_a = 6'(w.write_data & CTRL_MASK);
                        if (adapter_st.ctrl_a[C_C2_OUT])
                            adapter_st.c2_lvl[LVL_CA2] = adapter_st.ctrl_a[C_C2_B4] ?
                                adapter_st.ctrl_a[C_C2_B3] : 1'b1;
                    end
                    OFF_PORT_B:
                    begin
                        if (adapter_st.ctrl_b[C_PORT_SEL])
                        begin
                            adapter_st.out_b = w.write_data;
                            // strobe does not look at the output-enable bit
                            if (!adapter_st.ctrl_b[C_C2_B4])
                            begin
                                was_high = adapter_st.c2_lvl[LVL_CB2];
                                adapter_st.c2_lvl[LVL_CB2] = 1'b0;
                                if (adapter_st.ctrl_b[C_C2_B3])
                                begin
                                    adapter_st.c2_lvl[LVL_CB2] = 1'b1;
                                    strobe_b = was_high;
                                end
                            end
                        end
                        else
                        begin
                            adapter_st.dir_b = w.write_data;
                        end
                    end
                    default:
                    begin
                        adapter_st.ctrl_b = 6'(w.write_data & CTRL_MASK);
                        adapter_st.c2_lvl[LVL_CB2] = adapter_st.ctrl_b[C_C2_B4] ?
                            adapter_st.ctrl_b[C_C2_B3] : 1'b1;
                    end
                endcase
            end
            CMD_PINS:
            begin
                adapter_st.pins_a = w.port_a_pins;
                adapter_st.pins_b = w.port_b_pins;
                if (take_edge(LAT_CA1, w.ca1_level, adapter_st.ctrl_a[C_C1_EDGE]))
                begin
                    adapter_st.flags[FLG_A1] = 1'b1;
                    if (adapter_st.ctrl_a[C_C2_OUT] && !adapter_st.ctrl_a[C_C2_B4]
                        && !adapter_st.ctrl_a[C_C2_B3])
                        adapter_st.c2_lvl[LVL_CA2] = 1'b1;
                end
                hit = take_edge(LAT_CA2, w.ca2_level_in, adapter_st.ctrl_a[C_C2_B4]);
                if (hit && !adapter_st.ctrl_a[C_C2_OUT])
                    adapter_st.flags[FLG_A2] = 1'b1;
                if (take_edge(LAT_CB1, w.cb1_level, adapter_st.ctrl_b[C_C1_EDGE]))
                    adapter_st.flags[FLG_B1] = 1'b1;
                hit = take_edge(LAT_CB2, w.cb2_level_in, adapter_st.ctrl_b[C_C2_B4]);
                if (hit && !adapter_st.ctrl_b[C_C2_OUT])
                    adapter_st.flags[FLG_B2] = 1'b1;
            end
            default:
            begin
            end
        endcase

        r.read_data = rd;
        r.irq_a_line = (adapter_st.flags[FLG_A1] && adapter_st.ctrl_a[C_C1_IRQ_EN])
                    || (adapter_st.flags[FLG_A2] && adapter_st.ctrl_a[C_C2_B3]);
        r.irq_b_line = (adapter_st.flags[FLG_B1] && adapter_st.ctrl_b[C_C1_IRQ_EN])
                    || (adapter_st.flags[FLG_B2] && adapter_st.ctrl_b[C_C2_B3]);
        r.port_a_drive = (adapter_st.out_a & adapter_st.dir_a)
                       | (adapter_st.pins_a & ~adapter_st.dir_a);
        r.port_b_drive = adapter_st.out_b & adapter_st.dir_b;
        r.ca2_level_out = adapter_st.ctrl_a[C_C2_OUT] ? adapter_st.c2_lvl[LVL_CA2] : 1'b1;
        r.cb2_level_out = adapter_st.c2_lvl[LVL_CB2];
        r.ca2_strobe = strobe_a;
        r.cb2_strobe = strobe_b;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Word construction
    // ------------------------------------------------------------------
    // lines = {ca1, ca2, cb1, cb2}
    function automatic item_t word_of(input logic [1:0] cmd, input logic [1:0] off,
                                      input logic [7:0] wd, input logic [7:0] pa,
                                      input logic [7:0] pb, input logic [3:0] lines);
        item_t w;
        w.command = cmd;
        w.reg_offset = off;
        w.write_data = wd;
        w.port_a_pins = pa;
        w.port_b_pins = pb;
        {w.ca1_level, w.ca2_level_in, w.cb1_level, w.cb2_level_in} = lines;
        return w;
    endfunction

    function automatic void queue_word(input item_t w);
        plan_words.insert(plan_words.size(), w);
    endfunction

    function automatic void add_row(input item_t w, input bit typed, input result_t want);
        table_row_t row;
        row.word = w;
        row.typed = typed;
        row.want = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic item_t pins_word();
        return word_of(CMD_PINS, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       4'($urandom_range(0, 15)));
    endfunction

    // one side: optional DDR setup, control write, edges, status read, port access
    function automatic void plan_sequence();
        logic       side;
        logic [1:0] port_off;
        logic [1:0] ctrl_off;
        logic [7:0] ctrl_byte;
        int         n;
        side = 1'($urandom_range(0, 1));
        port_off = side ? OFF_PORT_B : OFF_PORT_A;
        ctrl_off = side ? OFF_CTRL_B : OFF_CTRL_A;
        if ($urandom_range(0, 3) == 0)
        begin
            ctrl_byte = 8'($urandom_range(0, 255));
            ctrl_byte[C_PORT_SEL] = 1'b0;
            queue_word(word_of(CMD_WRITE, ctrl_off, ctrl_byte, 8'h00, 8'h00, 4'h0));
            queue_word(word_of(CMD_WRITE, port_off, 8'($urandom_range(0, 255)),
                               8'h00, 8'h00, 4'h0));
        end
        ctrl_byte = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0)
            ctrl_byte[C_PORT_SEL] = 1'b1;
        queue_word(word_of(CMD_WRITE, ctrl_off, ctrl_byte, 8'h00, 8'h00, 4'h0));
        if ($urandom_range(0, 1) == 0)
            queue_word(word_of(CMD_WRITE, port_off, 8'($urandom_range(0, 255)),
                               8'h00, 8'h00, 4'h0));
        n = $urandom_range(1, 4);
        repeat (n)
            queue_word(pins_word());
        queue_word(word_of(CMD_READ, ctrl_off, 8'($urandom_range(0, 255)),
                           8'h00, 8'h00, 4'h0));
        queue_word(word_of($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, port_off,
                           8'($urandom_range(0, 255)), 8'h00, 8'h00, 4'h0));
        if ($urandom_range(0, 1) == 0)
            queue_word(word_of(CMD_READ, port_off, 8'h00, 8'h00, 8'h00, 4'h0));
    endfunction

    function automatic void plan_noise();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
            queue_word(word_of(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)),
                               4'($urandom_range(0, 15))));
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    task automatic send_word(input item_t w, input bit typed, input result_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= w.command;
        cmd_ch.reg_offset   <= w.reg_offset;
        cmd_ch.write_data   <= w.write_data;
        cmd_ch.port_a_pins  <= w.port_a_pins;
        cmd_ch.port_b_pins  <= w.port_b_pins;
        cmd_ch.ca1_level    <= w.ca1_level;
        cmd_ch.ca2_level_in <= w.ca2_level_in;
        cmd_ch.cb1_level    <= w.cb1_level;
        cmd_ch.cb2_level_in <= w.cb2_level_in;
        offering = 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        want = typed ? want : next_result(w);
        if (typed)
            void'(next_result(w));
        awaited_results.insert(awaited_results.size(), want);
    endtask

    task automatic drain_results();
        if (offering)
        begin
            cmd_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result word with nothing awaited");
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("read_data", res_ch.read_data, want.read_data);
                compare_field("irq_a_line", 8'(res_ch.irq_a_line), 8'(want.irq_a_line));
                compare_field("irq_b_line", 8'(res_ch.irq_b_line), 8'(want.irq_b_line));
                compare_field("port_a_drive", res_ch.port_a_drive, want.port_a_drive);
                compare_field("port_b_drive", res_ch.port_b_drive, want.port_b_drive);
                compare_field("ca2_level_out", 8'(res_ch.ca2_level_out),
                              8'(want.ca2_level_out));
                compare_field("cb2_level_out", 8'(res_ch.cb2_level_out),
                              8'(want.cb2_level_out));
                compare_field("ca2_strobe", 8'(res_ch.ca2_strobe), 8'(want.ca2_strobe));
                compare_field("cb2_strobe", 8'(res_ch.cb2_strobe), 8'(want.cb2_strobe));
            end
        end
    end

    // ------------------------------------------------------------------
    // Clock, receiver, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        mode = RX_STREAM;
        mode_left = 0;
        hold_left = 0;
        phase = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            phase++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_STREAM:  res_ch.ready <= 1'b1;
                    RX_RANDOM:  res_ch.ready <= ($urandom_range(0, 2) != 0);
                    RX_PATTERN: res_ch.ready <= ((phase % 5) < 3);
                    default:    res_ch.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        item_t w;
        int    random_count;
        int    hold_at;
        int    pause_at;
        bit    hold_done;
        bit    pause_done;
        random_count = 0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        hold_at = $urandom_range(80, 200);
        pause_at = $urandom_range(250, 400);

        rst_n               <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.command      <= CMD_READ;
        cmd_ch.reg_offset   <= OFF_PORT_A;
        cmd_ch.write_data   <= 8'h00;
        cmd_ch.port_a_pins  <= 8'h00;
        cmd_ch.port_b_pins  <= 8'h00;
        cmd_ch.ca1_level    <= 1'b0;
        cmd_ch.ca2_level_in <= 1'b0;
        cmd_ch.cb1_level    <= 1'b0;
        cmd_ch.cb2_level_in <= 1'b0;

        // quiet reads and an unused command right after reset, then the C2 output modes and edge flags
        add_row(word_of(CMD_READ, OFF_PORT_A, 8'h00, 8'h00, 8'h00, 4'h0),
                1'b1, RESULT_AFTER_RESET);
        add_row(word_of(CMD_NONE, OFF_CTRL_B, 8'hFF, 8'hFF, 8'hFF, 4'hF),
                1'b1, RESULT_AFTER_RESET);
        add_row(word_of(CMD_READ, OFF_CTRL_B, 8'h00, 8'h00, 8'h00, 4'h0),
                1'b1, RESULT_AFTER_RESET);
        add_row(word_of(CMD_WRITE, OFF_PORT_A, 8'hFF, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        // bits 7 and 6 of a control write are dropped
        add_row(word_of(CMD_WRITE, OFF_CTRL_A, 8'hFF, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_WRITE, OFF_PORT_A, 8'hA5, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_WRITE, OFF_PORT_B, 8'hFF, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_WRITE, OFF_CTRL_B, 8'h2D, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        // port B write pulses CB2
        add_row(word_of(CMD_WRITE, OFF_PORT_B, 8'h5A, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_PINS, OFF_PORT_A, 8'h00, 8'h00, 8'hFF, 4'hF), 1'b0, '0);
        add_row(word_of(CMD_READ, OFF_CTRL_A, 8'h00, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_PINS, OFF_PORT_A, 8'h00, 8'hFF, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_READ, OFF_CTRL_B, 8'h00, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        // CA2 strobe released by CA1
        add_row(word_of(CMD_WRITE, OFF_CTRL_A, 8'h25, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_READ, OFF_PORT_A, 8'h00, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_PINS, OFF_PORT_A, 8'h00, 8'h3C, 8'hC3, 4'h8), 1'b0, '0);
        add_row(word_of(CMD_PINS, OFF_PORT_A, 8'h00, 8'h3C, 8'hC3, 4'h0), 1'b0, '0);
        // CA2 strobe restored at end of the read
        add_row(word_of(CMD_WRITE, OFF_CTRL_A, 8'h2D, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_READ, OFF_PORT_A, 8'h00, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        // CB2 strobe released by a port B read after a CB1 edge
        add_row(word_of(CMD_WRITE, OFF_CTRL_B, 8'h25, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_WRITE, OFF_PORT_B, 8'h00, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_PINS, OFF_PORT_A, 8'h00, 8'h00, 8'h00, 4'h2), 1'b0, '0);
        add_row(word_of(CMD_PINS, OFF_PORT_A, 8'h00, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_READ, OFF_PORT_B, 8'h00, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        // C2 as input: CA2 rising edge flags, then a CB2 falling edge flags
        add_row(word_of(CMD_WRITE, OFF_CTRL_A, 8'h1B, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_PINS, OFF_PORT_A, 8'h00, 8'h55, 8'hAA, 4'h5), 1'b0, '0);
        add_row(word_of(CMD_READ, OFF_CTRL_A, 8'h00, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_WRITE, OFF_CTRL_B, 8'h08, 8'h00, 8'h00, 4'h0), 1'b0, '0);
        add_row(word_of(CMD_PINS, OFF_PORT_A, 8'h00, 8'h55, 8'hAA, 4'h4), 1'b0, '0);
        add_row(word_of(CMD_READ, OFF_CTRL_B, 8'h00, 8'h00, 8'h00, 4'h0), 1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        while (random_count < RANDOM_WORDS)
        begin
            if (plan_words.size() == 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    plan_noise();
                else
                    plan_sequence();
            end
            w = plan_words.pop_front();
            send_word(w, 1'b0, '0);
            if (w.command != CMD_NONE)
                random_count++;
            if (!hold_done && random_count >= hold_at)
            begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && random_count >= pause_at)
            begin
                drain_results();
                pause_done = 1'b1;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
